>>> design/srsw_pkg.sv
// shared types and constants of the selective-repeat sender window
package srsw_pkg;

	localparam int SEQ_SPACE_DEF  = 256;
	localparam int MAX_WINDOW_DEF = 32;
	localparam int CMDQ_DEPTH     = 2;

	localparam int KIND_W   = 2;
	localparam int SEQ_FW   = 8;
	localparam int RES_W    = 3;
	localparam int WIN_FW   = 6;
	localparam int TMR_W    = 16;
	localparam int CFG_DW   = 16;
	localparam int CFG_IW   = 1;

	localparam logic [WIN_FW-1:0] WINDOW_SIZE_RST = WIN_FW'(8);
	localparam logic [TMR_W-1:0]  TIMEOUT_RST     = TMR_W'(200);

	typedef enum logic [CFG_IW-1:0] {
		CFG_WINDOW_SIZE   = 1'b0,
		CFG_TIMEOUT_TICKS = 1'b1
	} cfg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		IN_SEND = 2'd0,
		IN_ACK  = 2'd1,
		IN_NACK = 2'd2,
		IN_TICK = 2'd3
	} in_kind_t;

	typedef enum logic [RES_W-1:0] {
		RES_SENT      = 3'd0,
		RES_FULL      = 3'd1,
		RES_RETX      = 3'd2,
		RES_ACK       = 3'd3,
		RES_IGNORED   = 3'd4,
		RES_TICK_DONE = 3'd5
	} res_kind_t;

	typedef enum logic [1:0] {
		OP_SEND   = 2'd0,
		OP_ACK    = 2'd1,
		OP_IGNORE = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_SEND     = 3'd1,
		ST_ACK      = 3'd2,
		ST_ADV      = 3'd3,
		ST_TICK     = 3'd4,
		ST_TICK_UPD = 3'd5,
		ST_EMIT     = 3'd6
	} back_state_t;

	typedef struct packed {
		op_t              op;
		logic [SEQ_FW-1:0] seq;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic [WIN_FW-1:0] window_size;
		logic [TMR_W-1:0]  timeout_ticks;
	} cfg_t;

endpackage

>>> design/srsw_req_if.sv
// input channel: event words into the sender window
interface srsw_req_if;
	logic                         valid;
	logic                         ready;
	logic [srsw_pkg::KIND_W-1:0]  kind;
	logic [srsw_pkg::SEQ_FW-1:0]  ack_seq;
	logic                         ack_corrupt;

	modport source (output valid, kind, ack_seq, ack_corrupt, input ready);
	modport sink (input valid, kind, ack_seq, ack_corrupt, output ready);
endinterface

>>> design/srsw_rsp_if.sv
// output channel: result words from the sender window
interface srsw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [srsw_pkg::RES_W-1:0]   result_kind;
	logic [srsw_pkg::SEQ_FW-1:0]  seq;
	logic [srsw_pkg::SEQ_FW-1:0]  window_base;
	logic [srsw_pkg::WIN_FW-1:0]  in_flight;
	logic                         last;

	modport source (output valid, result_kind, seq, window_base, in_flight, last, input ready);
	modport sink (input valid, result_kind, seq, window_base, in_flight, last, output ready);
endinterface

>>> design/srsw_front.sv
// front end: accepts event words and classifies them into commands
module srsw_front #(
	parameter int SEQ_SPACE = srsw_pkg::SEQ_SPACE_DEF
) (
	srsw_req_if.sink         req,
	input  srsw_pkg::qstat_t stat,
	output logic             push,
	output srsw_pkg::cmd_t   cmd
);

	logic seq_ok;

	assign seq_ok   = 9'(req.ack_seq) < 9'(SEQ_SPACE);
	assign req.ready = !stat.full;
	assign push      = req.valid && !stat.full;

	always_comb begin
		cmd.seq = req.ack_seq;
		case (req.kind)
			srsw_pkg::IN_SEND: cmd.op = srsw_pkg::OP_SEND;
			srsw_pkg::IN_ACK: begin
				if (!req.ack_corrupt && seq_ok) cmd.op = srsw_pkg::OP_ACK;
				else cmd.op = srsw_pkg::OP_IGNORE;
			end
			srsw_pkg::IN_TICK: cmd.op = srsw_pkg::OP_TICK;
			default: cmd.op = srsw_pkg::OP_IGNORE;
		endcase
	end

endmodule

>>> design/srsw_cmd_q.sv
// short command queue between front end and window engine
module srsw_cmd_q (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  srsw_pkg::cmd_t   wdata,
	input  logic             pop,
	output srsw_pkg::cmd_t   head,
	output srsw_pkg::qstat_t stat
);

	localparam int DEPTH = srsw_pkg::CMDQ_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	srsw_pkg::cmd_t ent_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign stat.full  = cnt_q == CW'(DEPTH);
	assign stat.empty = cnt_q == '0;
	assign head       = ent_q[rd_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> design/srsw_back.sv
// window engine: sequence state, timer memory, window walks and result register
module srsw_back #(
	parameter int SEQ_SPACE  = srsw_pkg::SEQ_SPACE_DEF,
	parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  srsw_pkg::cfg_t   cfg,
	input  srsw_pkg::cmd_t   head,
	input  srsw_pkg::qstat_t stat,
	output logic             q_pop,
	srsw_rsp_if.source       rsp
);

	localparam int SEQ_W  = $clog2(SEQ_SPACE);
	localparam int EMIT_W = $clog2(MAX_WINDOW + 1);
	localparam int TMR_W  = srsw_pkg::TMR_W;
	localparam int SEQ_FW = srsw_pkg::SEQ_FW;
	localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_SPACE - 1);

	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
		return (s == SEQ_LAST) ? '0 : s + 1'b1;
	endfunction

	srsw_pkg::back_state_t state_q, state_d;

	logic [SEQ_SPACE-1:0] outst_q;
	logic [SEQ_W-1:0]     base_q;
	logic [SEQ_W-1:0]     next_q;
	logic [SEQ_W-1:0]     ptr_q;
	logic [SEQ_W-1:0]     rem_q;
	logic [EMIT_W-1:0]    emit_cnt_q;
	logic                 pend_q;
	srsw_pkg::res_kind_t  res_kind_q;
	logic [SEQ_FW-1:0]    res_seq_q;

	logic [TMR_W-1:0] tmr_mem [SEQ_SPACE];
	logic [TMR_W-1:0] tmr_rdata_q;
	logic             tmr_we;
	logic [SEQ_W-1:0] tmr_waddr;
	logic [TMR_W-1:0] tmr_wdata;
	logic             tmr_re;

	logic                        rsp_valid_q;
	srsw_pkg::res_kind_t         rsp_kind_q;
	logic [SEQ_FW-1:0]           rsp_seq_q;
	logic [SEQ_FW-1:0]           rsp_base_q;
	logic [srsw_pkg::WIN_FW-1:0] rsp_inflight_q;
	logic                        rsp_last_q;

	logic [SEQ_W-1:0] cnt;
	logic             room;
	logic             out_ok;
	logic             out_load;
	logic             out_last;
	logic             adv;
	logic             scan_done;
	logic             expire;
	logic             upd_go;

	assign cnt = SEQ_W'((SEQ_W + 1)'(next_q)
		+ ((next_q >= base_q) ? '0 : (SEQ_W + 1)'(SEQ_SPACE))
		- (SEQ_W + 1)'(base_q));
	assign room = (9'(cnt) < 9'(cfg.window_size)) && (9'(cnt) < 9'(MAX_WINDOW))
		&& (9'(cnt) < 9'(SEQ_SPACE - 1));
	assign out_ok    = !rsp_valid_q || rsp.ready;
	assign adv       = (base_q != next_q) && !outst_q[base_q];
	assign scan_done = (rem_q == '0) || (emit_cnt_q == EMIT_W'(MAX_WINDOW));
	assign expire    = tmr_rdata_q <= TMR_W'(1);
	assign upd_go    = !(expire && pend_q && !out_ok);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			srsw_pkg::ST_IDLE: begin
				if (!stat.empty) begin
					case (head.op)
						srsw_pkg::OP_SEND: state_d = srsw_pkg::ST_SEND;
						srsw_pkg::OP_ACK: state_d = srsw_pkg::ST_ACK;
						srsw_pkg::OP_TICK: state_d = srsw_pkg::ST_TICK;
						default: state_d = srsw_pkg::ST_EMIT;
					endcase
				end
			end
			srsw_pkg::ST_SEND: state_d = srsw_pkg::ST_EMIT;
			srsw_pkg::ST_ACK: state_d = srsw_pkg::ST_ADV;
			srsw_pkg::ST_ADV: begin
				if (!adv) state_d = srsw_pkg::ST_EMIT;
			end
			srsw_pkg::ST_TICK: begin
				if (scan_done) state_d = srsw_pkg::ST_EMIT;
				else if (outst_q[ptr_q]) state_d = srsw_pkg::ST_TICK_UPD;
			end
			srsw_pkg::ST_TICK_UPD: begin
				if (upd_go) state_d = srsw_pkg::ST_TICK;
			end
			srsw_pkg::ST_EMIT: begin
				if (out_ok) state_d = srsw_pkg::ST_IDLE;
			end
			default: state_d = srsw_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop     = 1'b0;
		tmr_we    = 1'b0;
		tmr_waddr = next_q;
		tmr_wdata = cfg.timeout_ticks;
		tmr_re    = 1'b0;
		out_load  = 1'b0;
		out_last  = 1'b1;
		case (state_q)
			srsw_pkg::ST_IDLE: q_pop = !stat.empty;
			srsw_pkg::ST_SEND: tmr_we = room;
			srsw_pkg::ST_TICK: tmr_re = !scan_done && outst_q[ptr_q];
			srsw_pkg::ST_TICK_UPD: begin
				tmr_waddr = ptr_q;
				tmr_we    = upd_go;
				if (!expire) tmr_wdata = tmr_rdata_q - 1'b1;
				// earlier retransmit goes out before the new one is held
				if (expire && pend_q) begin
					out_load = out_ok;
					out_last = 1'b0;
				end
			end
			srsw_pkg::ST_EMIT: out_load = out_ok;
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tmr_we) tmr_mem[tmr_waddr] <= tmr_wdata;
	end

	always_ff @(posedge clk) begin
		if (tmr_re) tmr_rdata_q <= tmr_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= srsw_pkg::ST_IDLE;
			outst_q    <= '0;
			base_q     <= '0;
			next_q     <= '0;
			ptr_q      <= '0;
			rem_q      <= '0;
			emit_cnt_q <= '0;
			pend_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				srsw_pkg::ST_IDLE: begin
					if (!stat.empty && head.op == srsw_pkg::OP_TICK) begin
						ptr_q      <= base_q;
						rem_q      <= cnt;
						emit_cnt_q <= '0;
						pend_q     <= 1'b0;
					end
				end
				srsw_pkg::ST_SEND: begin
					if (room) begin
						outst_q[next_q] <= 1'b1;
						next_q          <= seq_inc(next_q);
					end
				end
				srsw_pkg::ST_ACK: outst_q[res_seq_q[SEQ_W-1:0]] <= 1'b0;
				srsw_pkg::ST_ADV: begin
					if (adv) base_q <= seq_inc(base_q);
				end
				srsw_pkg::ST_TICK: begin
					if (!scan_done && !outst_q[ptr_q]) begin
						ptr_q <= seq_inc(ptr_q);
						rem_q <= rem_q - 1'b1;
					end
				end
				srsw_pkg::ST_TICK_UPD: begin
					if (upd_go) begin
						ptr_q <= seq_inc(ptr_q);
						rem_q <= rem_q - 1'b1;
						if (expire) begin
							pend_q     <= 1'b1;
							emit_cnt_q <= emit_cnt_q + 1'b1;
						end
					end
				end
				default: pend_q <= pend_q;
			endcase
		end
	end

	// result fields held for the emit
	always_ff @(posedge clk) begin
		case (state_q)
			srsw_pkg::ST_IDLE: begin
				res_seq_q <= head.seq;
				if (head.op == srsw_pkg::OP_ACK) res_kind_q <= srsw_pkg::RES_ACK;
				else res_kind_q <= srsw_pkg::RES_IGNORED;
			end
			srsw_pkg::ST_SEND: begin
				res_seq_q  <= SEQ_FW'(next_q);
				res_kind_q <= room ? srsw_pkg::RES_SENT : srsw_pkg::RES_FULL;
			end
			srsw_pkg::ST_TICK: begin
				if (scan_done && !pend_q) begin
					res_seq_q  <= '0;
					res_kind_q <= srsw_pkg::RES_TICK_DONE;
				end
			end
			srsw_pkg::ST_TICK_UPD: begin
				if (upd_go && expire) begin
					res_seq_q  <= SEQ_FW'(ptr_q);
					res_kind_q <= srsw_pkg::RES_RETX;
				end
			end
			default: res_seq_q <= res_seq_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (out_load) rsp_valid_q <= 1'b1;
		else if (rsp.ready) rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_kind_q     <= res_kind_q;
			rsp_seq_q      <= res_seq_q;
			rsp_base_q     <= SEQ_FW'(base_q);
			rsp_inflight_q <= srsw_pkg::WIN_FW'(cnt);
			rsp_last_q     <= out_last;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_kind = rsp_kind_q;
	assign rsp.seq         = rsp_seq_q;
	assign rsp.window_base = rsp_base_q;
	assign rsp.in_flight   = rsp_inflight_q;
	assign rsp.last        = rsp_last_q;

endmodule

>>> design/selective_repeat_sender_window_core.sv
// selective-repeat arq sender window, top level: config registers, front end, queue, engine
// steps: send takes the next sequence number or reports full; an ignored word just gives its result;
// ack clears the outstanding flag, then walks the base; tick counts down outstanding timers
// flow: one word at a time in the engine, set by the base walk and the tick scan through the
// timer memory; the queue takes up to 2 words ahead. reset: arst_n clears window state,
// outstanding flags and queue and loads config defaults; timers are not cleared
module selective_repeat_sender_window_core #(
	parameter int SEQ_SPACE  = srsw_pkg::SEQ_SPACE_DEF,
	parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	srsw_req_if.sink                      req,
	srsw_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [srsw_pkg::CFG_IW-1:0]   cfg_idx,
	input  logic [srsw_pkg::CFG_DW-1:0]   cfg_wdata
);

	srsw_pkg::cfg_t   cfg_q;
	srsw_pkg::cmd_t   push_cmd;
	srsw_pkg::cmd_t   head;
	srsw_pkg::qstat_t q_stat;
	logic             q_push;
	logic             q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size   <= srsw_pkg::WINDOW_SIZE_RST;
			cfg_q.timeout_ticks <= srsw_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				srsw_pkg::CFG_WINDOW_SIZE:
					cfg_q.window_size <= cfg_wdata[srsw_pkg::WIN_FW-1:0];
				srsw_pkg::CFG_TIMEOUT_TICKS:
					cfg_q.timeout_ticks <= cfg_wdata[srsw_pkg::TMR_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	srsw_front #(
		.SEQ_SPACE(SEQ_SPACE)
	) u_front (
		.req  (req),
		.stat (q_stat),
		.push (q_push),
		.cmd  (push_cmd)
	);

	srsw_cmd_q u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_cmd),
		.pop    (q_pop),
		.head   (head),
		.stat   (q_stat)
	);

	srsw_back #(
		.SEQ_SPACE  (SEQ_SPACE),
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.stat   (q_stat),
		.q_pop  (q_pop),
		.rsp    (rsp)
	);

`ifndef SYNTHESIS
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("command popped from empty queue");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("command pushed into full queue");

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> q_push)
		else $error("accepted word not queued");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.full && !q_pop) |=> !q_stat.empty)
		else $error("queue lost entries without a pop");
`endif

endmodule
